// ===== hw/rtl/scot_pkg.sv =====
// ----------------------------------------------------------------------------
// scot_pkg: shared types and constants of the sorted client order table
// Table sizes, derived widths, entry layouts and result codes.
// ----------------------------------------------------------------------------
package scot_pkg;

    localparam int MAX_CLIENTS = 32;
    localparam int MAX_ORDERS  = 16;

    localparam int CI_W  = $clog2(MAX_CLIENTS);
    localparam int OI_W  = $clog2(MAX_ORDERS);
    localparam int CC_W  = $clog2(MAX_CLIENTS + 1);
    localparam int OC_W  = $clog2(MAX_ORDERS + 1);
    localparam int ORD_DEPTH = MAX_CLIENTS * MAX_ORDERS;
    localparam int OA_W  = $clog2(ORD_DEPTH);
    // Widths wide enough to compare requested slots against counts.
    localparam int KC_W  = (CC_W > 5) ? CC_W : 5;
    localparam int KO_W  = (OC_W > 4) ? OC_W : 4;

    localparam int ID_W   = 27;
    localparam int CODE_W = 20;
    localparam int DATE_W = 27;

    localparam logic [27:0] YEAR_MUL  = 28'd10000;
    localparam logic [10:0] MONTH_MUL = 11'd100;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_CLIENT_FULL = 2'd1,
        ST_ORDER_FULL  = 2'd2,
        ST_EMPTY       = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [OC_W-1:0] cnt;
        logic [CI_W-1:0] row;
    } cent_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DATE_W-1:0] date;
    } oent_t;

    typedef struct packed {
        status_t           status;
        logic [4:0]        client_slot;
        logic [3:0]        order_slot;
        logic              new_client;
        logic [ID_W-1:0]   out_client_id;
        logic [CODE_W-1:0] out_order_code;
        logic [DATE_W-1:0] out_date;
        logic [4:0]        out_order_count;
        logic [5:0]        client_total;
    } res_t;

    function automatic logic [OA_W-1:0] ord_addr(logic [CI_W-1:0] row,
                                                 logic [OI_W-1:0] os);
        return OA_W'(row) * OA_W'(MAX_ORDERS) + OA_W'(os);
    endfunction

endpackage

// ===== hw/rtl/scot_req_if.sv =====
// ----------------------------------------------------------------------------
// scot_req_if: request channel of the sorted client order table
// Valid/ready channel carrying one insert or read request per beat.
// ----------------------------------------------------------------------------
interface scot_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [26:0] client_id;
    logic [19:0] order_code;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  read_client_slot;
    logic [3:0]  read_order_slot;

    modport source (output valid, opcode, client_id, order_code, day, month, year,
                    read_client_slot, read_order_slot, input ready);
    modport sink (input valid, opcode, client_id, order_code, day, month, year,
                  read_client_slot, read_order_slot, output ready);
endinterface

// ===== hw/rtl/scot_rsp_if.sv =====
// ----------------------------------------------------------------------------
// scot_rsp_if: response channel of the sorted client order table
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface scot_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  client_slot;
    logic [3:0]  order_slot;
    logic        new_client;
    logic [26:0] out_client_id;
    logic [19:0] out_order_code;
    logic [26:0] out_date;
    logic [4:0]  out_order_count;
    logic [5:0]  client_total;

    modport source (output valid, status, client_slot, order_slot, new_client,
                    out_client_id, out_order_code, out_date, out_order_count,
                    client_total, input ready);
    modport sink (input valid, status, client_slot, order_slot, new_client,
                  out_client_id, out_order_code, out_date, out_order_count,
                  client_total, output ready);
endinterface

// ===== hw/rtl/scot_core.sv =====
// ----------------------------------------------------------------------------
// scot_core: sequencer and table memories
// Walks the client and order memories one entry per step to search, shift,
// insert and read.
// ----------------------------------------------------------------------------
module scot_core
    import scot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_opcode,
    input  logic [26:0] in_client_id,
    input  logic [19:0] in_order_code,
    input  logic [4:0]  in_day,
    input  logic [3:0]  in_month,
    input  logic [13:0] in_year,
    input  logic [4:0]  in_rcs,
    input  logic [3:0]  in_ros,
    input  logic        res_free,
    output logic        res_valid,
    output res_t        res
);

    typedef enum logic [4:0] {
        S_IDLE, S_DATE1, S_DATE2, S_SRCH_RD, S_SRCH_CMP, S_CSH_RD, S_CSH_WR,
        S_CNEW, S_OSCAN_RD, S_OSCAN_CMP, S_OSH_RD, S_OSH_WR, S_OWRITE, S_CUPD,
        S_RD_CLI, S_RD_CHK, S_RD_OUT, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [ID_W-1:0]   id_reg, id_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [4:0]        day_reg, day_next;
    logic [3:0]        mon_reg, mon_next;
    logic [13:0]       year_reg, year_next;
    logic [4:0]        rcs_reg, rcs_next;
    logic [3:0]        ros_reg, ros_next;
    logic [27:0]       prod_reg, prod_next;
    logic [10:0]       small_reg, small_next;
    logic [DATE_W-1:0] date_reg, date_next;
    logic [CC_W-1:0]   count_reg, count_next;
    logic [CC_W-1:0]   idx_reg, idx_next;
    logic [CI_W-1:0]   slot_reg, slot_next;
    logic [CI_W-1:0]   row_reg, row_next;
    logic [OC_W-1:0]   n_reg, n_next;
    logic [OC_W-1:0]   pos_reg, pos_next;
    logic [OC_W-1:0]   jo_reg, jo_next;
    logic              found_reg, found_next;
    res_t              res_reg, res_next;

    cent_t client_mem [MAX_CLIENTS];
    oent_t order_mem [ORD_DEPTH];
    cent_t cli_rd_reg;
    oent_t ord_rd_reg;

    logic [CI_W-1:0] cli_raddr, cli_waddr;
    logic            cli_we;
    cent_t           cli_wdata;
    logic [OA_W-1:0] ord_raddr, ord_waddr;
    logic            ord_we;
    oent_t           ord_wdata;
    logic [27:0]     date_sum;

    always_ff @(posedge clk)
    begin
        if (cli_we)
        begin
            client_mem[cli_waddr] <= cli_wdata;
        end
        cli_rd_reg <= client_mem[cli_raddr];
        if (ord_we)
        begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        ord_rd_reg <= order_mem[ord_raddr];
    end

    assign date_sum  = prod_reg + 28'(small_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) && res_free;

    always_comb
    begin
        res = res_reg;
        res.client_total = 6'(count_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        code_next  = code_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        rcs_next   = rcs_reg;
        ros_next   = ros_reg;
        prod_next  = prod_reg;
        small_next = small_reg;
        date_next  = date_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        row_next   = row_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        jo_next    = jo_reg;
        found_next = found_reg;
        res_next   = res_reg;
        cli_raddr  = '0;
        cli_we     = 1'b0;
        cli_waddr  = '0;
        cli_wdata  = '0;
        ord_raddr  = '0;
        ord_we     = 1'b0;
        ord_waddr  = '0;
        ord_wdata  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next   = in_client_id;
                    code_next = in_order_code;
                    day_next  = in_day;
                    mon_next  = in_month;
                    year_next = in_year;
                    rcs_next  = in_rcs;
                    ros_next  = in_ros;
                    res_next  = '0;
                    state_next = (in_opcode == OP_READ) ? S_RD_CLI : S_DATE1;
                end
            end
            S_DATE1:
            begin
                prod_next  = 28'(year_reg) * YEAR_MUL;
                small_next = 11'(mon_reg) * MONTH_MUL + 11'(day_reg);
                state_next = S_DATE2;
            end
            S_DATE2:
            begin
                date_next  = date_sum[27] ? '1 : date_sum[DATE_W-1:0];
                idx_next   = '0;
                state_next = S_SRCH_RD;
            end
            S_SRCH_RD:
            begin
                cli_raddr = CI_W'(idx_reg);
                if (idx_reg == count_reg)
                begin
                    // Client absent and larger than every stored id.
                    if (count_reg >= CC_W'(MAX_CLIENTS))
                    begin
                        res_next.status         = ST_CLIENT_FULL;
                        res_next.out_client_id  = id_reg;
                        res_next.out_order_code = code_reg;
                        res_next.out_date       = date_reg;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        slot_next  = CI_W'(count_reg);
                        state_next = S_CNEW;
                    end
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (cli_rd_reg.id == id_reg)
                begin
                    slot_next  = CI_W'(idx_reg);
                    row_next   = cli_rd_reg.row;
                    n_next     = cli_rd_reg.cnt;
                    found_next = 1'b1;
                    pos_next   = '0;
                    if (cli_rd_reg.cnt >= OC_W'(MAX_ORDERS))
                    begin
                        res_next.status          = ST_ORDER_FULL;
                        res_next.client_slot     = 5'(idx_reg);
                        res_next.out_client_id   = id_reg;
                        res_next.out_order_code  = code_reg;
                        res_next.out_date        = date_reg;
                        res_next.out_order_count = 5'(cli_rd_reg.cnt);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_OSCAN_RD;
                    end
                end
                else if (id_reg < cli_rd_reg.id)
                begin
                    if (count_reg >= CC_W'(MAX_CLIENTS))
                    begin
                        res_next.status         = ST_CLIENT_FULL;
                        res_next.out_client_id  = id_reg;
                        res_next.out_order_code = code_reg;
                        res_next.out_date       = date_reg;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // Open a gap: move entries count-1 .. idx up by one.
                        slot_next  = CI_W'(idx_reg);
                        idx_next   = count_reg;
                        state_next = S_CSH_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_CSH_RD:
            begin
                cli_raddr  = CI_W'(idx_reg - 1'b1);
                state_next = S_CSH_WR;
            end
            S_CSH_WR:
            begin
                cli_we    = 1'b1;
                cli_waddr = CI_W'(idx_reg);
                cli_wdata = cli_rd_reg;
                idx_next  = idx_reg - 1'b1;
                state_next = (CI_W'(idx_reg - 1'b1) == slot_reg) ? S_CNEW : S_CSH_RD;
            end
            S_CNEW:
            begin
                // Rows of the order memory are handed out in arrival order.
                row_next   = CI_W'(count_reg);
                count_next = count_reg + 1'b1;
                n_next     = '0;
                pos_next   = '0;
                found_next = 1'b0;
                state_next = S_OSCAN_RD;
            end
            S_OSCAN_RD:
            begin
                ord_raddr = ord_addr(row_reg, OI_W'(pos_reg));
                if (pos_reg == n_reg)
                begin
                    jo_next    = n_reg;
                    state_next = S_OWRITE;
                end
                else
                begin
                    state_next = S_OSCAN_CMP;
                end
            end
            S_OSCAN_CMP:
            begin
                if (ord_rd_reg.date <= date_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_OSCAN_RD;
                end
                else
                begin
                    jo_next    = n_reg;
                    state_next = S_OSH_RD;
                end
            end
            S_OSH_RD:
            begin
                ord_raddr  = ord_addr(row_reg, OI_W'(jo_reg - 1'b1));
                state_next = S_OSH_WR;
            end
            S_OSH_WR:
            begin
                ord_we    = 1'b1;
                ord_waddr = ord_addr(row_reg, OI_W'(jo_reg));
                ord_wdata = ord_rd_reg;
                jo_next   = jo_reg - 1'b1;
                state_next = ((jo_reg - 1'b1) == pos_reg) ? S_OWRITE : S_OSH_RD;
            end
            S_OWRITE:
            begin
                ord_we         = 1'b1;
                ord_waddr      = ord_addr(row_reg, OI_W'(pos_reg));
                ord_wdata.code = code_reg;
                ord_wdata.date = date_reg;
                state_next     = S_CUPD;
            end
            S_CUPD:
            begin
                cli_we        = 1'b1;
                cli_waddr     = slot_reg;
                cli_wdata.id  = id_reg;
                cli_wdata.cnt = n_reg + 1'b1;
                cli_wdata.row = row_reg;
                res_next.status          = ST_OK;
                res_next.client_slot     = 5'(slot_reg);
                res_next.order_slot      = 4'(pos_reg);
                res_next.new_client      = !found_reg;
                res_next.out_client_id   = id_reg;
                res_next.out_order_code  = code_reg;
                res_next.out_date        = date_reg;
                res_next.out_order_count = 5'(n_reg + 1'b1);
                state_next = S_EMIT;
            end
            S_RD_CLI:
            begin
                cli_raddr = CI_W'(rcs_reg);
                res_next.client_slot = rcs_reg;
                res_next.order_slot  = ros_reg;
                if (KC_W'(rcs_reg) >= KC_W'(count_reg))
                begin
                    res_next.status = ST_EMPTY;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD_CHK;
                end
            end
            S_RD_CHK:
            begin
                row_next = cli_rd_reg.row;
                res_next.out_client_id   = cli_rd_reg.id;
                res_next.out_order_count = 5'(cli_rd_reg.cnt);
                ord_raddr = ord_addr(cli_rd_reg.row, OI_W'(ros_reg));
                if (KO_W'(ros_reg) >= KO_W'(cli_rd_reg.cnt))
                begin
                    res_next.status = ST_EMPTY;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD_OUT;
                end
            end
            S_RD_OUT:
            begin
                res_next.status         = ST_OK;
                res_next.out_order_code = ord_rd_reg.code;
                res_next.out_date       = ord_rd_reg.date;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        code_reg  <= code_next;
        day_reg   <= day_next;
        mon_reg   <= mon_next;
        year_reg  <= year_next;
        rcs_reg   <= rcs_next;
        ros_reg   <= ros_next;
        prod_reg  <= prod_next;
        small_reg <= small_next;
        date_reg  <= date_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        row_reg   <= row_next;
        n_reg     <= n_next;
        pos_reg   <= pos_next;
        jo_reg    <= jo_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

endmodule

// ===== hw/rtl/sorted_client_order_table.sv =====
// ----------------------------------------------------------------------------
// sorted_client_order_table: two-level sorted client and order table
// Top level with request and response channels and the response register.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel, one beat per item: an insert
// (client id, order code, date) or a read (client slot, order slot). Every
// request yields exactly one beat on the rsp channel.
// An insert first forms the date key, then scans the clients up to the match
// or insert point, shifts stored clients up when a new client goes in front
// of them, scans the orders by date, moves the later orders up, and finally
// writes the order and the client entry. Each step is one access of the
// client or order memory with a registered read, followed by a compare. A
// read fetches the client entry and then, for an occupied slot, the order
// entry. The block takes one item at a time; req.ready is high only while
// the sequencer is idle.
// Order rows are never moved: a new client gets the next free row, and only
// the small client entry (id, count, row) is shifted to keep ids sorted.
// Reset empties the table at once (client count zero); no clearing pass.
// A finished result sits in the response register, so the next request can
// be taken while the receiver stalls; a second result waits in the sequencer
// until the register frees up.
// ----------------------------------------------------------------------------
module sorted_client_order_table
    import scot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    scot_req_if.sink   req,
    scot_rsp_if.source rsp
);

    logic res_free;
    logic res_valid;
    res_t res;
    logic out_valid_reg;
    res_t out_reg;

    assign res_free = !out_valid_reg || rsp.ready;

    scot_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .in_opcode    (req.opcode),
        .in_client_id (req.client_id),
        .in_order_code(req.order_code),
        .in_day       (req.day),
        .in_month     (req.month),
        .in_year      (req.year),
        .in_rcs       (req.read_client_slot),
        .in_ros       (req.read_order_slot),
        .res_free     (res_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.client_slot     = out_reg.client_slot;
    assign rsp.order_slot      = out_reg.order_slot;
    assign rsp.new_client      = out_reg.new_client;
    assign rsp.out_client_id   = out_reg.out_client_id;
    assign rsp.out_order_code  = out_reg.out_order_code;
    assign rsp.out_date        = out_reg.out_date;
    assign rsp.out_order_count = out_reg.out_order_count;
    assign rsp.client_total    = out_reg.client_total;

endmodule

// ===== hw/rtl/scot_checker.sv =====
// ----------------------------------------------------------------------------
// scot_checker: port-level checks of the sorted client order table
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module scot_checker
    import scot_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic       rsp_new_client,
    input logic [4:0] rsp_count,
    input logic [5:0] rsp_total
);

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("stalled response changed");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_total <= 6'(MAX_CLIENTS))
        else $error("client total beyond table size");

    a_new_client: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_new_client |-> rsp_status == ST_OK && rsp_count == 5'd1)
        else $error("new client without a single order");

endmodule

bind sorted_client_order_table scot_checker u_scot_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_new_client(rsp.new_client),
    .rsp_count     (rsp.out_order_count),
    .rsp_total     (rsp.client_total)
);

// ===== sim/tb_sorted_client_order_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_client_order_table: self-checking bench of the sorted order table
// A table of directed requests is followed by random inserts and reads drawn
// from a small pool of client ids, so that the client table and the order
// lists fill up. Every response beat is checked against a hand-typed result or a
// behavioral model. Both channels idle at random, save in the last of three phases.
// ----------------------------------------------------------------------------
module tb_sorted_client_order_table;
    import scot_pkg::*;

    // A response beat that takes longer than this, with the receiver stalling
    // on top, means the block has hung.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POOL_SIZE      = 64;
    localparam int ITEMS_PER_PHASE = 330;

    typedef struct {
        logic        opcode;
        logic [26:0] client_id;
        logic [19:0] order_code;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  rd_client;
        logic [3:0]  rd_order;
        bit          typed;
        res_t        result;
    } request_t;

    logic clk;
    logic rst_n;

    scot_req_if req ();
    scot_rsp_if rsp ();

    sorted_client_order_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the table, kept in step with every accepted request.
    logic [26:0] shadow_ids   [MAX_CLIENTS];
    logic [4:0]  shadow_count [MAX_CLIENTS];
    logic [19:0] shadow_code  [MAX_CLIENTS][MAX_ORDERS];
    logic [26:0] shadow_date  [MAX_CLIENTS][MAX_ORDERS];
    int          shadow_clients;

    res_t        pending_results [$];
    logic [26:0] id_pool [POOL_SIZE];
    int          mismatches;
    int          stall_cycles;
    int          sender_idle_pct;
    int          receiver_idle_pct;

    // Compute the response to one request and update the shadow table.
    task automatic apply_request(input request_t r, output res_t e);
        logic [31:0] date;
        int          slot;
        int          pos;
        int          n;
        bit          found;

        e = '0;
        if (r.opcode == OP_READ) begin
            e.client_slot = r.rd_client;
            e.order_slot  = r.rd_order;
            e.client_total = 6'(shadow_clients);
            if (int'(r.rd_client) >= shadow_clients) begin
                e.status = ST_EMPTY;
            end
            else begin
                n = shadow_count[r.rd_client];
                e.out_client_id   = shadow_ids[r.rd_client];
                e.out_order_count = 5'(n);
                if (int'(r.rd_order) >= n) begin
                    e.status = ST_EMPTY;
                end
                else begin
                    e.status         = ST_OK;
                    e.out_order_code = shadow_code[r.rd_client][r.rd_order];
                    e.out_date       = shadow_date[r.rd_client][r.rd_order];
                end
            end
            return;
        end

        // The date key saturates when out-of-range fields push it past 27 bits.
        date = 32'(r.year) * 32'd10000 + 32'(r.month) * 32'd100 + 32'(r.day);
        if (date > 32'h7FF_FFFF)
            date = 32'h7FF_FFFF;
        e.out_client_id  = r.client_id;
        e.out_order_code = r.order_code;
        e.out_date       = date[26:0];

        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < shadow_clients; i++) begin
            if (!found && shadow_ids[i] == r.client_id) begin
                slot  = i;
                found = 1'b1;
            end
        end

        if (!found) begin
            if (shadow_clients >= MAX_CLIENTS) begin
                e.status       = ST_CLIENT_FULL;
                e.client_total = 6'(shadow_clients);
                return;
            end
            slot = shadow_clients;
            for (int i = shadow_clients - 1; i >= 0; i--) begin
                if (r.client_id < shadow_ids[i])
                    slot = i;
            end
            for (int i = shadow_clients; i > slot; i--) begin
                shadow_ids[i]   = shadow_ids[i-1];
                shadow_count[i] = shadow_count[i-1];
                shadow_code[i]  = shadow_code[i-1];
                shadow_date[i]  = shadow_date[i-1];
            end
            shadow_ids[slot]   = r.client_id;
            shadow_count[slot] = '0;
            shadow_clients++;
        end
        else if (shadow_count[slot] >= MAX_ORDERS) begin
            e.status          = ST_ORDER_FULL;
            e.client_slot     = 5'(slot);
            e.out_order_count = shadow_count[slot];
            e.client_total    = 6'(shadow_clients);
            return;
        end

        // New orders go after any order with an equal date.
        n   = shadow_count[slot];
        pos = 0;
        while (pos < n && shadow_date[slot][pos] <= date[26:0])
            pos++;
        for (int i = n; i > pos; i--) begin
            shadow_code[slot][i] = shadow_code[slot][i-1];
            shadow_date[slot][i] = shadow_date[slot][i-1];
        end
        shadow_code[slot][pos] = r.order_code;
        shadow_date[slot][pos] = date[26:0];
        shadow_count[slot]     = 5'(n + 1);

        e.status          = ST_OK;
        e.client_slot     = 5'(slot);
        e.order_slot      = 4'(pos);
        e.new_client      = !found;
        e.out_order_count = 5'(n + 1);
        e.client_total    = 6'(shadow_clients);
    endtask

    // Drive one request beat and hold it until the block takes it. The valid
    // line is left high so that a back-to-back beat needs no second write.
    task automatic send_request(input request_t r);
        res_t e;

        while ($urandom_range(99) < sender_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid            <= 1'b1;
        req.opcode           <= r.opcode;
        req.client_id        <= r.client_id;
        req.order_code       <= r.order_code;
        req.day              <= r.day;
        req.month            <= r.month;
        req.year             <= r.year;
        req.read_client_slot <= r.rd_client;
        req.read_order_slot  <= r.rd_order;
        do
            @(posedge clk);
        while (!req.ready);
        apply_request(r, e);
        pending_results.push_back(r.typed ? r.result : e);
    endtask

    // Hold the sender off until every outstanding response has come back.
    task automatic drain;
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic request_t insert_req(logic [26:0] id, logic [19:0] code,
                                            logic [4:0] d, logic [3:0] m,
                                            logic [13:0] y);
        request_t r;
        r = '{default: '0};
        r.opcode     = OP_INSERT;
        r.client_id  = id;
        r.order_code = code;
        r.day        = d;
        r.month      = m;
        r.year       = y;
        r.rd_client  = 5'($urandom());
        r.rd_order   = 4'($urandom());
        return r;
    endfunction

    function automatic request_t read_req(logic [4:0] cs, logic [3:0] os);
        request_t r;
        r = '{default: '0};
        r.opcode     = OP_READ;
        r.client_id  = 27'($urandom());
        r.order_code = 20'($urandom());
        r.day        = 5'($urandom());
        r.month      = 4'($urandom());
        r.year       = 14'($urandom());
        r.rd_client  = cs;
        r.rd_order   = os;
        return r;
    endfunction

    function automatic res_t typed_result(status_t st, int cs, int os, bit nc,
                                          logic [26:0] id, logic [19:0] code,
                                          logic [26:0] date, int cnt, int total);
        res_t e;
        e.status          = st;
        e.client_slot     = 5'(cs);
        e.order_slot      = 4'(os);
        e.new_client      = nc;
        e.out_client_id   = id;
        e.out_order_code  = code;
        e.out_date        = date;
        e.out_order_count = 5'(cnt);
        e.client_total    = 6'(total);
        return e;
    endfunction

    function automatic request_t random_request();
        request_t r;
        logic [26:0] id;
        if ($urandom_range(99) < 30) begin
            // Mostly reads of occupied client slots, now and then past the end.
            if ($urandom_range(9) < 8 && shadow_clients > 0)
                r = read_req(5'($urandom_range(shadow_clients - 1)),
                             4'($urandom_range(MAX_ORDERS - 1)));
            else
                r = read_req(5'($urandom()), 4'($urandom()));
            return r;
        end
        id = ($urandom_range(9) == 0) ? 27'($urandom()) : id_pool[$urandom_range(POOL_SIZE-1)];
        if ($urandom_range(99) < 85)
            r = insert_req(id, 20'($urandom()), 5'($urandom_range(31, 1)),
                           4'($urandom_range(12, 1)), 14'($urandom_range(9999)));
        else
            r = insert_req(id, 20'($urandom()), 5'($urandom()), 4'($urandom()),
                           14'($urandom()));
        return r;
    endfunction

    // Response side: check each accepted beat, then pick the next ready.
    always @(posedge clk) begin
        res_t actual;
        res_t expected;
        if (rst_n) begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL sorted_client_order_table");
                $finish;
            end
            if (rsp.valid && rsp.ready) begin
                actual.status          = status_t'(rsp.status);
                actual.client_slot     = rsp.client_slot;
                actual.order_slot      = rsp.order_slot;
                actual.new_client      = rsp.new_client;
                actual.out_client_id   = rsp.out_client_id;
                actual.out_order_code  = rsp.out_order_code;
                actual.out_date        = rsp.out_date;
                actual.out_order_count = rsp.out_order_count;
                actual.client_total    = rsp.client_total;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response beat: %p", actual);
                end
                else begin
                    expected = pending_results.pop_front();
                    if (actual !== expected) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p",
                                     expected, actual);
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial begin
        request_t directed [$];
        request_t r;
        int       wait_cycles;

        req.valid            = 1'b0;
        req.opcode           = OP_INSERT;
        req.client_id        = '0;
        req.order_code       = '0;
        req.day              = '0;
        req.month            = '0;
        req.year             = '0;
        req.read_client_slot = '0;
        req.read_order_slot  = '0;
        rsp.ready            = 1'b0;
        rst_n                = 1'b0;
        mismatches           = 0;
        stall_cycles         = 0;
        shadow_clients       = 0;
        sender_idle_pct      = 26;
        receiver_idle_pct    = 74;

        id_pool[0] = 27'd0;
        id_pool[1] = 27'h7FF_FFFF;
        id_pool[2] = 27'd500;
        for (int i = 3; i < POOL_SIZE; i++)
            id_pool[i] = 27'($urandom_range(99999999));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Rows with a typed result are plain enough to read
        // off by hand; the rest go through the model.
        r = read_req(5'd0, 4'd0);
        r.typed = 1; r.result = typed_result(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0);
        directed.push_back(r);
        r = insert_req(27'd500, 20'd1, 5'd1, 4'd1, 14'd2000);
        r.typed = 1;
        r.result = typed_result(ST_OK, 0, 0, 1, 27'd500, 20'd1, 27'd20000101, 1, 1);
        directed.push_back(r);
        // Lowest id lands in front and shifts client 500 up.
        r = insert_req(27'd0, 20'hFFFFF, 5'd0, 4'd0, 14'd0);
        r.typed = 1;
        r.result = typed_result(ST_OK, 0, 0, 1, 27'd0, 20'hFFFFF, 27'd0, 1, 2);
        directed.push_back(r);
        // All-ones date fields overflow the key, which then saturates.
        r = insert_req(27'h7FF_FFFF, 20'd0, 5'h1F, 4'hF, 14'h3FFF);
        r.typed = 1;
        r.result = typed_result(ST_OK, 2, 0, 1, 27'h7FF_FFFF, 20'd0, 27'h7FF_FFFF, 1, 3);
        directed.push_back(r);
        // An equal date goes behind the order already there.
        r = insert_req(27'd500, 20'd7, 5'd1, 4'd1, 14'd2000);
        r.typed = 1;
        r.result = typed_result(ST_OK, 1, 1, 0, 27'd500, 20'd7, 27'd20000101, 2, 3);
        directed.push_back(r);
        directed.push_back(insert_req(27'd500, 20'd9, 5'd31, 4'd12, 14'd1999));
        directed.push_back(insert_req(27'd9999, 20'd3, 5'd31, 4'd12, 14'd9999));
        directed.push_back(read_req(5'd1, 4'd0));
        directed.push_back(read_req(5'd1, 4'd2));
        directed.push_back(read_req(5'd1, 4'd3));
        directed.push_back(read_req(5'd5, 4'd0));
        directed.push_back(read_req(5'd31, 4'd15));
        directed.push_back(read_req(5'd3, 4'd0));
        foreach (directed[i])
            send_request(directed[i]);

        // Fill the list of client 0 past its limit to see the order-full case.
        for (int i = 0; i < MAX_ORDERS; i++)
            send_request(insert_req(27'd0, 20'($urandom()), 5'($urandom_range(31, 1)),
                                    4'($urandom_range(12, 1)), 14'($urandom_range(9999))));
        send_request(read_req(5'd0, 4'd15));

        // Random phases: receiver lazy, then sender lazy, then no idling.
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            sender_idle_pct   = (phase == 0) ? 26 : (phase == 1) ? 74 : 0;
            receiver_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 26 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(random_request());
        end

        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 300) begin
            @(posedge clk);
            wait_cycles++;
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS sorted_client_order_table");
        else
            $display("FAIL sorted_client_order_table");
        $finish;
    end

endmodule

// ===== sorted_client_order_table.f =====
hw/rtl/scot_pkg.sv
hw/rtl/scot_req_if.sv
hw/rtl/scot_rsp_if.sv
hw/rtl/scot_core.sv
hw/rtl/sorted_client_order_table.sv
hw/rtl/scot_checker.sv
sim/tb_sorted_client_order_table.sv
